// File: rtl/chtu_pkg.sv
// Package with the shared types, codes and sizes of the chained hash table unit.
`timescale 1ns / 1ps
package chtu_pkg;

    localparam int MAX_BUCKETS  = 256;
    localparam int MAX_ENTRIES  = 1024;
    localparam int BUCKET_W     = $clog2(MAX_BUCKETS);
    localparam int ENTRY_W      = $clog2(MAX_ENTRIES);
    localparam int LINK_W       = ENTRY_W + 1;
    localparam int BCOUNT_W     = 9;
    localparam int HASH_W       = 32;
    localparam int OBJ_W        = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int BCOUNT_RESET = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [BUCKET_W-1:0] bucket;
        logic [OBJ_W-1:0]    obj;
        logic [ENTRY_W-1:0]  entry_ref;
    } t_work;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HEAD,
        B_LINK,
        B_OBJ
    } t_back_state;

endpackage

// File: rtl/chtu_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module chtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/chtu_front.sv
// Front end: accepts command beats and, for insert and chain start, reduces the hash to a bucket one bit per cycle.
`timescale 1ns / 1ps
module chtu_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [chtu_pkg::CMD_W-1:0]       i_cmd,
    input  logic [chtu_pkg::HASH_W-1:0]      i_hash_value,
    input  logic [chtu_pkg::OBJ_W-1:0]       i_object_index,
    input  logic [chtu_pkg::ENTRY_W-1:0]     i_entry_ref,
    input  logic [chtu_pkg::BCOUNT_W-1:0]    i_bucket_count,
    output logic                             o_work_valid,
    input  logic                             i_work_ready,
    output chtu_pkg::t_work                  o_work
);
    import chtu_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    t_front_state         r_state, n_state;
    logic [CMD_W-1:0]     r_cmd;
    logic [HASH_W-1:0]    r_hash, n_hash;
    logic [OBJ_W-1:0]     r_obj;
    logic [ENTRY_W-1:0]   r_ref;
    logic [BCOUNT_W-1:0]  r_div, w_div;
    logic [BCOUNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [BCOUNT_W:0]    w_trial;
    logic                 w_accept;
    logic                 w_needs_div;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_needs_div = (i_cmd == CMD_INSERT) || (i_cmd == CMD_START);

    always_comb begin
        if (i_bucket_count == '0) begin
            w_div = BCOUNT_W'(1);
        end else if (i_bucket_count > BCOUNT_W'(MAX_BUCKETS)) begin
            w_div = BCOUNT_W'(MAX_BUCKETS);
        end else begin
            w_div = i_bucket_count;
        end
    end

    assign w_trial = {r_rem, r_hash[HASH_W-1]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = w_needs_div ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_work_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == F_IDLE);
        o_work_valid = (r_state == F_PUSH);
        n_rem        = r_rem;
        n_hash       = r_hash;
        n_cnt        = r_cnt;
        if (r_state == F_IDLE) begin
            n_rem  = '0;
            n_cnt  = '0;
            n_hash = i_hash_value;
        end else if (r_state == F_DIV) begin
            n_hash = {r_hash[HASH_W-2:0], 1'b0};
            n_cnt  = r_cnt + CNT_W'(1);
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = BCOUNT_W'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = BCOUNT_W'(w_trial);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_hash <= n_hash;
        r_cnt  <= n_cnt;
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_obj <= i_object_index;
            r_ref <= i_entry_ref;
            r_div <= w_div;
        end
    end

    assign o_work.cmd       = r_cmd;
    assign o_work.bucket    = r_rem[BUCKET_W-1:0];
    assign o_work.obj       = r_obj;
    assign o_work.entry_ref = r_ref;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV) |-> (r_rem < r_div))
        else $error("Remainder reached the divisor.");
endmodule

// File: rtl/chtu_fifo.sv
// Two-entry queue that carries classified work from the front end to the back end.
`timescale 1ns / 1ps
module chtu_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  chtu_pkg::t_work i_wr_data,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output chtu_pkg::t_work o_rd_data
);
    import chtu_pkg::*;

    t_work      r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_wr_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("Queue count out of range.");
endmodule

// File: rtl/chtu_back.sv
// Back end: carries out inserts and lookups on the head, link and object memories.
`timescale 1ns / 1ps
module chtu_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_work_valid,
    output logic                             o_work_ready,
    input  chtu_pkg::t_work                  i_work,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [chtu_pkg::STATUS_W-1:0]    o_status,
    output logic [chtu_pkg::ENTRY_W-1:0]     o_result_entry,
    output logic [chtu_pkg::OBJ_W-1:0]       o_result_object
);
    import chtu_pkg::*;

    t_back_state         r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [BUCKET_W-1:0] r_bucket;
    logic [OBJ_W-1:0]    r_obj;
    logic [LINK_W-1:0]   r_ptr, n_ptr;
    logic [LINK_W-1:0]   r_total, n_total;
    logic [MAX_BUCKETS-1:0] r_head_vld;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ENTRY_W-1:0]  r_res_entry, n_res_entry;
    logic [OBJ_W-1:0]    r_res_obj, n_res_obj;

    logic                head_we, head_re;
    logic [BUCKET_W-1:0] head_addr;
    logic [LINK_W-1:0]   head_wdata, head_q;
    logic                link_we, link_re;
    logic [ENTRY_W-1:0]  link_waddr, link_raddr;
    logic [LINK_W-1:0]   link_wdata, link_q;
    logic                obj_we, obj_re;
    logic [ENTRY_W-1:0]  obj_raddr;
    logic [OBJ_W-1:0]    obj_q;

    logic                w_out_free, w_take, w_full;
    logic [LINK_W-1:0]   w_head, w_total_p1, w_ptr_m1, w_head_m1, w_link_m1;
    logic                w_head_empty, w_link_more;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_work_ready = (r_state == B_IDLE) && w_out_free;
    assign w_take       = i_work_valid && o_work_ready;
    assign w_full       = (r_total >= LINK_W'(MAX_ENTRIES));
    assign w_head       = r_head_vld[r_bucket] ? head_q : '0;
    assign w_total_p1   = r_total + LINK_W'(1);
    assign w_ptr_m1     = r_ptr - LINK_W'(1);
    assign w_head_m1    = w_head - LINK_W'(1);
    assign w_link_m1    = link_q - LINK_W'(1);
    assign w_head_empty = (w_head == '0) || (w_head > r_total);
    assign w_link_more  = (link_q != '0) && (link_q <= r_total);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (w_take) begin
                    if (i_work.cmd == CMD_INSERT && !w_full) begin
                        n_state = B_HEAD;
                    end else if (i_work.cmd == CMD_START) begin
                        n_state = B_HEAD;
                    end else if (i_work.cmd == CMD_NEXT
                                 && LINK_W'(i_work.entry_ref) < r_total) begin
                        n_state = B_LINK;
                    end
                end
            end
            B_HEAD: begin
                if (r_cmd == CMD_INSERT) begin
                    n_state = w_head_empty ? B_IDLE : B_LINK;
                end else begin
                    n_state = w_head_empty ? B_IDLE : B_OBJ;
                end
            end
            B_LINK: begin
                if (r_cmd == CMD_INSERT) begin
                    n_state = w_link_more ? B_LINK : B_IDLE;
                end else begin
                    n_state = w_link_more ? B_OBJ : B_IDLE;
                end
            end
            B_OBJ: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        head_we     = 1'b0;
        head_re     = 1'b0;
        head_addr   = r_bucket;
        head_wdata  = w_total_p1;
        link_we     = 1'b0;
        link_re     = 1'b0;
        link_waddr  = r_total[ENTRY_W-1:0];
        link_wdata  = '0;
        link_raddr  = i_work.entry_ref;
        obj_we      = 1'b0;
        obj_re      = 1'b0;
        obj_raddr   = w_head_m1[ENTRY_W-1:0];
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_out_valid = (r_out_valid && !i_out_ready);
        n_status    = r_status;
        n_res_entry = r_res_entry;
        n_res_obj   = r_res_obj;
        unique case (r_state)
            B_IDLE: begin
                head_addr = i_work.bucket;
                if (w_take) begin
                    n_res_entry = '0;
                    n_res_obj   = '0;
                    if (i_work.cmd == CMD_INSERT) begin
                        if (w_full) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_FULL;
                        end else begin
                            obj_we  = 1'b1;
                            link_we = 1'b1;
                            head_re = 1'b1;
                        end
                    end else if (i_work.cmd == CMD_START) begin
                        head_re = 1'b1;
                    end else if (i_work.cmd == CMD_NEXT
                                 && LINK_W'(i_work.entry_ref) < r_total) begin
                        link_re = 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NONE;
                    end
                end
            end
            B_HEAD: begin
                n_ptr = w_head;
                if (r_cmd == CMD_INSERT) begin
                    if (w_head_empty) begin
                        head_we     = 1'b1;
                        n_total     = w_total_p1;
                        n_out_valid = 1'b1;
                        n_status    = ST_OK;
                        n_res_entry = r_total[ENTRY_W-1:0];
                        n_res_obj   = r_obj;
                    end else begin
                        link_re    = 1'b1;
                        link_raddr = w_head_m1[ENTRY_W-1:0];
                    end
                end else if (w_head == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NONE;
                end else if (w_head > r_total) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CORRUPT;
                end else begin
                    obj_re    = 1'b1;
                    obj_raddr = w_head_m1[ENTRY_W-1:0];
                end
            end
            B_LINK: begin
                if (r_cmd == CMD_INSERT) begin
                    if (w_link_more) begin
                        n_ptr      = link_q;
                        link_re    = 1'b1;
                        link_raddr = w_link_m1[ENTRY_W-1:0];
                    end else begin
                        link_we     = 1'b1;
                        link_waddr  = w_ptr_m1[ENTRY_W-1:0];
                        link_wdata  = w_total_p1;
                        n_total     = w_total_p1;
                        n_out_valid = 1'b1;
                        n_status    = ST_OK;
                        n_res_entry = r_total[ENTRY_W-1:0];
                        n_res_obj   = r_obj;
                    end
                end else if (link_q == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NONE;
                end else if (link_q > r_total) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CORRUPT;
                end else begin
                    n_ptr     = link_q;
                    obj_re    = 1'b1;
                    obj_raddr = w_link_m1[ENTRY_W-1:0];
                end
            end
            B_OBJ: begin
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_res_entry = w_ptr_m1[ENTRY_W-1:0];
                n_res_obj   = obj_q;
            end
            default: n_out_valid = r_out_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_total     <= '0;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (head_we) begin
                r_head_vld[r_bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_status    <= n_status;
        r_res_entry <= n_res_entry;
        r_res_obj   <= n_res_obj;
        if (w_take) begin
            r_cmd    <= i_work.cmd;
            r_bucket <= i_work.bucket;
            r_obj    <= i_work.obj;
        end
    end

    chtu_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_bucket),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (head_addr),
        .o_rdata (head_q)
    );

    chtu_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    chtu_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_ENTRIES)) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (obj_we),
        .i_waddr (r_total[ENTRY_W-1:0]),
        .i_wdata (i_work.obj),
        .i_re    (obj_re),
        .i_raddr (obj_raddr),
        .o_rdata (obj_q)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_entry  = r_res_entry;
    assign o_result_object = r_res_obj;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= LINK_W'(MAX_ENTRIES))
        else $error("Entry count exceeds the table size.");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LINK && r_cmd == CMD_INSERT) |-> (r_ptr != '0 && r_ptr <= r_total))
        else $error("Chain walk left the used entries.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_total != r_total) |-> (n_out_valid && n_status == ST_OK && r_state != B_IDLE))
        else $error("Entry count changed without a completed insert.");
endmodule

// File: rtl/chained_hash_table_unit.sv
// Top level of the chained hash table unit: configuration register, front end, queue, back end.
//
// Commands arrive as beats on the input channel (i_in_valid / o_in_ready) and each one
// produces exactly one result beat on the output channel (o_out_valid / i_out_ready).
// The user must write the bucket count on its own channel (i_cfg_valid / o_cfg_ready)
// only while no command is in flight; the block itself does not enforce this. The count
// resets to 16, and zero acts as 1 and values above 256 as 256. The front end reduces
// the hash to a bucket one quotient bit per cycle for insert and chain start; chain next
// and unknown commands skip that step. A two-beat queue separates the front end from the
// back end, which works through the memories with registered reads. A new command is
// taken once the front end has handed the previous one to the queue, even before the back
// end has finished it, and a long chain walk stalls the flow.
// Reset empties all buckets and the entry count; entry memories need no clearing pass.
// A result that is not taken holds the output register and stops the back end, which
// lets the queue fill and then stalls the input channel.
`timescale 1ns / 1ps
module chained_hash_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [chtu_pkg::CMD_W-1:0]       i_cmd,
    input  logic [chtu_pkg::HASH_W-1:0]      i_hash_value,
    input  logic [chtu_pkg::OBJ_W-1:0]       i_object_index,
    input  logic [chtu_pkg::ENTRY_W-1:0]     i_entry_ref,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [chtu_pkg::STATUS_W-1:0]    o_status,
    output logic [chtu_pkg::ENTRY_W-1:0]     o_result_entry,
    output logic [chtu_pkg::OBJ_W-1:0]       o_result_object,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [chtu_pkg::BCOUNT_W-1:0]    i_cfg_bucket_count
);
    import chtu_pkg::*;

    logic [BCOUNT_W-1:0] r_bucket_count;
    logic                fq_valid, fq_ready, qb_valid, qb_ready;
    t_work               fq_work, qb_work;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BCOUNT_W'(BCOUNT_RESET);
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_bucket_count;
        end
    end

    chtu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_hash_value   (i_hash_value),
        .i_object_index (i_object_index),
        .i_entry_ref    (i_entry_ref),
        .i_bucket_count (r_bucket_count),
        .o_work_valid   (fq_valid),
        .i_work_ready   (fq_ready),
        .o_work         (fq_work)
    );

    chtu_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_data  (fq_work),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_data  (qb_work)
    );

    chtu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work_valid    (qb_valid),
        .o_work_ready    (qb_ready),
        .i_work          (qb_work),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_result_entry  (o_result_entry),
        .o_result_object (o_result_object)
    );
endmodule
